// ===== rtl/core/bdm_pkg.sv =====
// shared constants and types for the bayer demosaic block
package bdm_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = COL_W + 1;
  localparam int ROW_W       = 16;
  localparam int BANK_W      = 3;
  localparam int BANKS       = 1 << BANK_W;
  localparam int ACC_W       = SAMPLE_BITS + 6;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);

  // configuration register indexes
  localparam logic [1:0] CFG_PATTERN = 2'd0;
  localparam logic [1:0] CFG_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_HEIGHT  = 2'd2;

  // color filter arrangements
  localparam logic [1:0] PAT_RGGB = 2'd0;
  localparam logic [1:0] PAT_BGGR = 2'd1;
  localparam logic [1:0] PAT_GRBG = 2'd2;
  localparam logic [1:0] PAT_GBRG = 2'd3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // block of pixels released by one input beat
  typedef struct packed {
    logic [ROW_W-1:0] y0;
    logic [1:0]       ny;
    logic [COL_W-1:0] x0;
    logic [1:0]       nx;
  } run_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [COL_W-1:0]  col;
    sample_t           data;
  } wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
  } rd_t;

endpackage

// ===== rtl/core/bdm_line_store.sv =====
// banked line store, one bank per kept row, one write and one read per bank
module bdm_line_store (
  input  logic                                         clk_i,
  input  bdm_pkg::wr_t                                 wr_i,
  input  bdm_pkg::rd_t                                 rd_i,
  output logic [bdm_pkg::BANKS-1:0][bdm_pkg::SAMPLE_BITS-1:0] rdata_o
);

  // each bank writes when addressed and reads the shared column
  for (genvar b = 0; b < bdm_pkg::BANKS; b++) begin : g_bank
    bdm_pkg::sample_t store_q [bdm_pkg::MAX_WIDTH];
    bdm_pkg::sample_t rdata_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.bank == b[bdm_pkg::BANK_W-1:0])) begin
        store_q[wr_i.col] <= wr_i.data;
      end
      if (rd_i.en) begin
        rdata_q <= store_q[rd_i.col];
      end
    end

    assign rdata_o[b] = rdata_q;
  end

endmodule

// ===== rtl/core/bdm_run_fifo.sv =====
// short queue of pixel runs between front and back
module bdm_run_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bdm_pkg::run_t run_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bdm_pkg::run_t run_o
);

  bdm_pkg::run_t               buf_q [bdm_pkg::Q_DEPTH];
  logic [bdm_pkg::Q_PTR_W-1:0] wp_q, rp_q;
  logic [bdm_pkg::Q_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (bdm_pkg::Q_PTR_W+1)'(bdm_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign run_o   = buf_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= run_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/bdm_front.sv =====
// input side: raster counters, line store writes and run classification
module bdm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bdm_pkg::sample_t           sample_i,
  input  logic [bdm_pkg::WID_W-1:0]  w_eff_i,
  input  logic [bdm_pkg::ROW_W-1:0]  h_eff_i,
  input  logic                       restart_i,
  input  logic                       back_idle_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output bdm_pkg::run_t              run_o,
  output bdm_pkg::wr_t               wr_o
);

  logic [bdm_pkg::ROW_W-1:0] row_q;
  logic [bdm_pkg::COL_W-1:0] col_q;
  logic                      drain_q;
  logic                      fire, col_end, row_end, row_ok, col_ok;
  logic [bdm_pkg::WID_W-1:0] w_m3;

  assign in_ready_o = !q_full_i && !drain_q;
  assign fire       = in_valid_i && in_ready_o;
  assign col_end    = ({1'b0, col_q} == (w_eff_i - 1'b1));
  assign row_end    = (row_q == (h_eff_i - 1'b1));
  assign w_m3       = w_eff_i - bdm_pkg::WID_W'(3);

  // which pixels this beat releases
  always_comb begin
    run_o  = '0;
    row_ok = 1'b0;
    col_ok = 1'b0;
    if (row_end) begin
      run_o.y0 = h_eff_i - bdm_pkg::ROW_W'(3);
      run_o.ny = 2'd2;
      row_ok   = 1'b1;
    end else if (row_q >= bdm_pkg::ROW_W'(2)) begin
      run_o.y0 = row_q - bdm_pkg::ROW_W'(2);
      row_ok   = 1'b1;
    end
    if (col_end) begin
      run_o.x0 = w_m3[bdm_pkg::COL_W-1:0];
      run_o.nx = 2'd2;
      col_ok   = 1'b1;
    end else if (col_q >= bdm_pkg::COL_W'(2)) begin
      run_o.x0 = col_q - bdm_pkg::COL_W'(2);
      col_ok   = 1'b1;
    end
  end

  assign push_o     = fire && row_ok && col_ok;
  assign wr_o.en    = fire;
  assign wr_o.bank  = row_q[bdm_pkg::BANK_W-1:0];
  assign wr_o.col   = col_q;
  assign wr_o.data  = sample_i;

  // raster position and end-of-frame drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      drain_q <= 1'b0;
    end else if (restart_i) begin
      row_q   <= '0;
      col_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      if (drain_q && back_idle_i) drain_q <= 1'b0;
      if (fire) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_end ? '0 : row_q + 1'b1;
          if (row_end) drain_q <= 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bdm_back.sv =====
// output side: pixel sequencer, 5x5 window, kernel sums and output register
module bdm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       run_valid_i,
  input  bdm_pkg::run_t              run_i,
  output logic                       run_pop_o,
  input  logic [bdm_pkg::WID_W-1:0]  w_eff_i,
  input  logic [bdm_pkg::ROW_W-1:0]  h_eff_i,
  input  logic [1:0]                 pattern_i,
  output bdm_pkg::rd_t               rd_o,
  input  logic [bdm_pkg::BANKS-1:0][bdm_pkg::SAMPLE_BITS-1:0] rdata_i,
  output logic                       idle_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [15:0]                red_value_o,
  output logic [15:0]                green_value_o,
  output logic [15:0]                blue_value_o,
  output logic [15:0]                pixel_row_o,
  output logic [11:0]                pixel_col_o,
  output logic                       last_of_run_o,
  output logic                       frame_end_o
);

  localparam int CW = bdm_pkg::COL_W;
  localparam int RW = bdm_pkg::ROW_W;
  localparam int AW = bdm_pkg::ACC_W;
  localparam int SB = bdm_pkg::SAMPLE_BITS;

  logic adv;

  // sequencer
  logic          busy_q, hist_q;
  bdm_pkg::run_t run_q;
  logic [RW-1:0] cy_q, ny;
  logic [CW-1:0] cx_q, nx, x_end;
  logic [RW-1:0] y_end;
  logic [2:0]    step_q;
  logic          pix_done, row_done, run_done, cont, take_run;

  // pipeline tags
  logic                     s1_vld_q, s1_done_q, s1_last_q;
  logic [RW-1:0]            s1_y_q;
  logic [CW-1:0]            s1_x_q;
  logic [4:0][bdm_pkg::BANK_W-1:0] s1_slot_q, slot;
  logic                     s2_vld_q, s2_last_q;
  logic [RW-1:0]            s2_y_q;
  logic [CW-1:0]            s2_x_q;
  logic                     s3_vld_q, s3_last_q;
  logic [RW-1:0]            s3_y_q;
  logic [CW-1:0]            s3_x_q;
  logic [3:0][AW-1:0]       s3_pos_q, s3_neg_q, pos, neg;
  bdm_pkg::sample_t         s3_own_q;

  bdm_pkg::sample_t win_q [5][5];
  logic [AW-1:0]    e [5][5];

  logic signed [CW+2:0] c_raw, c_mir, w_s;
  logic signed [RW+1:0] r_raw [5];
  logic signed [RW+1:0] r_mir [5];
  logic signed [RW+1:0] h_s;

  logic             out_valid_q, out_last_q, out_fend_q;
  bdm_pkg::sample_t out_r_q, out_g_q, out_b_q;
  logic [RW-1:0]    out_y_q;
  logic [CW-1:0]    out_x_q;

  assign adv = !out_valid_q || out_ready_i;

  // walk through the current run and pick the next pixel
  assign x_end    = run_q.x0 + CW'(run_q.nx);
  assign y_end    = run_q.y0 + RW'(run_q.ny);
  assign pix_done = (step_q == 3'd4);
  assign row_done = (cx_q == x_end);
  assign run_done = row_done && (cy_q == y_end);
  assign take_run = !busy_q || (pix_done && run_done);
  assign run_pop_o = adv && take_run && run_valid_i;

  always_comb begin
    if (take_run) begin
      ny = run_i.y0;
      nx = run_i.x0;
    end else if (row_done) begin
      ny = cy_q + 1'b1;
      nx = run_q.x0;
    end else begin
      ny = cy_q;
      nx = cx_q + 1'b1;
    end
    cont = hist_q && (ny == cy_q) && ({1'b0, nx} == ({1'b0, cx_q} + 1'b1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hist_q <= 1'b0;
      step_q <= '0;
      cy_q   <= '0;
      cx_q   <= '0;
      run_q  <= '0;
    end else if (adv) begin
      if (busy_q && !pix_done) begin
        step_q <= step_q + 1'b1;
      end else if (busy_q && !run_done) begin
        cy_q   <= ny;
        cx_q   <= nx;
        step_q <= cont ? 3'd4 : 3'd0;
      end else if (run_valid_i) begin
        run_q  <= run_i;
        busy_q <= 1'b1;
        hist_q <= 1'b1;
        cy_q   <= ny;
        cx_q   <= nx;
        step_q <= cont ? 3'd4 : 3'd0;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // mirrored column and row addresses for the column being fetched
  assign w_s   = $signed({2'b00, w_eff_i});
  assign h_s   = $signed({2'b00, h_eff_i});
  assign c_raw = $signed({3'b000, cx_q}) + $signed({{CW{1'b0}}, step_q}) - (CW+3)'(2);
  always_comb begin
    if (c_raw < 0)            c_mir = -c_raw;
    else if (c_raw >= w_s)    c_mir = (w_s <<< 1) - (CW+3)'(2) - c_raw;
    else                      c_mir = c_raw;
    for (int k = 0; k < 5; k++) begin
      r_raw[k] = $signed({2'b00, cy_q}) + (RW+2)'(k) - (RW+2)'(2);
      if (r_raw[k] < 0)         r_mir[k] = -r_raw[k];
      else if (r_raw[k] >= h_s) r_mir[k] = (h_s <<< 1) - (RW+2)'(2) - r_raw[k];
      else                      r_mir[k] = r_raw[k];
      slot[k] = r_mir[k][bdm_pkg::BANK_W-1:0];
    end
  end

  assign rd_o.en  = adv && busy_q;
  assign rd_o.col = c_mir[CW-1:0];

  // fetch tags travel with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= busy_q;
      s2_vld_q <= s1_vld_q && s1_done_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_done_q <= pix_done;
      s1_last_q <= pix_done && run_done;
      s1_y_q    <= cy_q;
      s1_x_q    <= cx_q;
      s1_slot_q <= slot;
      s2_last_q <= s1_last_q;
      s2_y_q    <= s1_y_q;
      s2_x_q    <= s1_x_q;
      s3_last_q <= s2_last_q;
      s3_y_q    <= s2_y_q;
      s3_x_q    <= s2_x_q;
      s3_pos_q  <= pos;
      s3_neg_q  <= neg;
      s3_own_q  <= win_q[2][2];
    end
  end

  // window shifts left by one column per returned read
  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 5; r++) begin
          win_q[c][r] <= win_q[c+1][r];
        end
      end
      for (int r = 0; r < 5; r++) begin
        win_q[4][r] <= rdata_i[s1_slot_q[r]];
      end
    end
  end

  // kernel sums, split into positive and negative taps
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        e[r][c] = AW'(win_q[c][r]);
      end
    end
    // green at red or blue
    pos[0] = ((e[1][2] + e[2][1] + e[2][3] + e[3][2]) << 2) + (e[2][2] << 3);
    neg[0] = (e[0][2] + e[2][0] + e[2][4] + e[4][2]) << 1;
    // same-row neighbor color at green
    pos[1] = e[0][2] + e[4][2] + ((e[2][1] + e[2][3]) << 3) + (e[2][2] << 3)
             + (e[2][2] << 1);
    neg[1] = (e[1][1] + e[1][3] + e[3][1] + e[3][3] + e[2][0] + e[2][4]) << 1;
    // other-row neighbor color at green
    pos[2] = e[2][0] + e[2][4] + ((e[1][2] + e[3][2]) << 3) + (e[2][2] << 3)
             + (e[2][2] << 1);
    neg[2] = (e[1][1] + e[1][3] + e[3][1] + e[3][3] + e[0][2] + e[4][2]) << 1;
    // diagonal color at red or blue
    pos[3] = ((e[1][1] + e[1][3] + e[3][1] + e[3][3]) << 2) + (e[2][2] << 3)
             + (e[2][2] << 2);
    neg[3] = ((e[0][2] + e[2][0] + e[2][4] + e[4][2]) << 1)
             + (e[0][2] + e[2][0] + e[2][4] + e[4][2]);
  end

  // divide by 16, clamp and round half up
  function automatic bdm_pkg::sample_t finish(input logic [AW-1:0] p,
                                              input logic [AW-1:0] n);
    logic signed [AW:0] acc;
    logic        [AW:0] v;
    acc = $signed({1'b0, p}) - $signed({1'b0, n});
    v   = (AW+1)'(acc + (AW+1)'(8)) >> 4;
    if (acc <= 0)                          finish = '0;
    else if (v > (AW+1)'({SB{1'b1}}))      finish = '1;
    else                                   finish = v[SB-1:0];
  endfunction

  logic             rr, rc, at_red, at_blue;
  bdm_pkg::sample_t f_rb_g, f_same, f_diff, f_cross;
  bdm_pkg::sample_t r_d, g_d, b_d;

  always_comb begin
    rr      = (pattern_i == bdm_pkg::PAT_BGGR) || (pattern_i == bdm_pkg::PAT_GBRG);
    rc      = (pattern_i == bdm_pkg::PAT_BGGR) || (pattern_i == bdm_pkg::PAT_GRBG);
    at_red  = (s3_y_q[0] == rr) && (s3_x_q[0] == rc);
    at_blue = (s3_y_q[0] != rr) && (s3_x_q[0] != rc);
    f_rb_g  = finish(s3_pos_q[0], s3_neg_q[0]);
    f_same  = finish(s3_pos_q[1], s3_neg_q[1]);
    f_diff  = finish(s3_pos_q[2], s3_neg_q[2]);
    f_cross = finish(s3_pos_q[3], s3_neg_q[3]);
    if (at_red) begin
      r_d = s3_own_q;
      g_d = f_rb_g;
      b_d = f_cross;
    end else if (at_blue) begin
      r_d = f_cross;
      g_d = f_rb_g;
      b_d = s3_own_q;
    end else if (s3_y_q[0] == rr) begin
      r_d = f_same;
      g_d = s3_own_q;
      b_d = f_diff;
    end else begin
      r_d = f_diff;
      g_d = s3_own_q;
      b_d = f_same;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_r_q    <= r_d;
      out_g_q    <= g_d;
      out_b_q    <= b_d;
      out_y_q    <= s3_y_q;
      out_x_q    <= s3_x_q;
      out_last_q <= s3_last_q;
      out_fend_q <= (s3_y_q == (h_eff_i - 1'b1)) &&
                    ({1'b0, s3_x_q} == (w_eff_i - 1'b1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_value_o   = 16'(out_r_q);
  assign green_value_o = 16'(out_g_q);
  assign blue_value_o  = 16'(out_b_q);
  assign pixel_row_o   = out_y_q;
  assign pixel_col_o   = 12'(out_x_q);
  assign last_of_run_o = out_last_q;
  assign frame_end_o   = out_fend_q;

  assign idle_o = !busy_q && !run_valid_i && !s1_vld_q && !s2_vld_q &&
                  !s3_vld_q && !out_valid_q;

endmodule

// ===== rtl/core/bayer_demosaic_5x5_linear_top.sv =====
// 5x5 linear bayer demosaic: config registers, front, run queue, line store, back
// the 5x5 window carries over from the previous pixel of a row; otherwise it is reloaded
//   from the line store, one column per read
// throughput: one pixel per cycle along a row while the output is not stalled; each new
//   output row reloads the window, and the last row of a frame releases three rows at once
// reset: registers return to rggb, 1920 x 1080, position 0; the line store is not cleared
module bayer_demosaic_5x5_linear_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] mosaic_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] red_value_o,
  output logic [15:0] green_value_o,
  output logic [15:0] blue_value_o,
  output logic [15:0] pixel_row_o,
  output logic [11:0] pixel_col_o,
  output logic        last_of_run_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [1:0]                pattern_q;
  logic [12:0]               width_q;
  logic [15:0]               height_q;
  logic [bdm_pkg::WID_W-1:0] w_eff;
  logic [bdm_pkg::ROW_W-1:0] h_eff;
  logic                      cfg_fire, restart;

  logic          q_full, q_valid, q_push, q_pop, back_idle;
  bdm_pkg::run_t run_in, run_out;
  bdm_pkg::wr_t  wr;
  bdm_pkg::rd_t  rd;
  logic [bdm_pkg::BANKS-1:0][bdm_pkg::SAMPLE_BITS-1:0] rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_fire && ((cfg_index_i == bdm_pkg::CFG_WIDTH) ||
                                    (cfg_index_i == bdm_pkg::CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= bdm_pkg::PAT_RGGB;
      width_q   <= 13'd1920;
      height_q  <= 16'd1080;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        bdm_pkg::CFG_PATTERN: pattern_q <= cfg_data_i[1:0];
        bdm_pkg::CFG_WIDTH:   width_q   <= cfg_data_i[12:0];
        bdm_pkg::CFG_HEIGHT:  height_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (width_q < 13'd4)                         w_eff = bdm_pkg::WID_W'(4);
    else if ({1'b0, width_q} > 14'(bdm_pkg::MAX_WIDTH))
                                                 w_eff = bdm_pkg::WID_W'(bdm_pkg::MAX_WIDTH);
    else                                         w_eff = bdm_pkg::WID_W'(width_q);
    h_eff = (height_q < 16'd4) ? 16'd4 : height_q;
  end

  bdm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (mosaic_sample_i[bdm_pkg::SAMPLE_BITS-1:0]),
    .w_eff_i     (w_eff),
    .h_eff_i     (h_eff),
    .restart_i   (restart),
    .back_idle_i (back_idle),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .run_o       (run_in),
    .wr_o        (wr)
  );

  bdm_run_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .run_i   (run_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .run_o   (run_out)
  );

  bdm_line_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  bdm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_valid_i   (q_valid),
    .run_i         (run_out),
    .run_pop_o     (q_pop),
    .w_eff_i       (w_eff),
    .h_eff_i       (h_eff),
    .pattern_i     (pattern_q),
    .rd_o          (rd),
    .rdata_i       (rdata),
    .idle_o        (back_idle),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_value_o   (red_value_o),
    .green_value_o (green_value_o),
    .blue_value_o  (blue_value_o),
    .pixel_row_o   (pixel_row_o),
    .pixel_col_o   (pixel_col_o),
    .last_of_run_o (last_of_run_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

// ===== verif/bayer_demosaic_5x5_linear_top_tb.sv =====
// testbench for the 5x5 linear bayer demosaic: directed frames, then random frames
module bayer_demosaic_5x5_linear_top_tb;

  typedef enum int {KER_GREEN, KER_SAME_ROW, KER_DIFF_ROW, KER_CROSS} kernel_e;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] row;
    logic [11:0] col;
    logic        last;
    logic        fend;
  } rgb_pixel_t;

  typedef struct {
    logic [15:0] sample;
    logic        flat;
  } mosaic_row_t;

  localparam int KEPT_ROWS   = 5;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 170;

  // register index that the block ignores
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // doubled malvar-he-cutler kernels
  localparam int K_GREEN [0:24] = '{ 0, 0, -2, 0,  0,   0, 0,  4, 0,  0,
                                    -2, 4,  8, 4, -2,   0, 0,  4, 0,  0,
                                     0, 0, -2, 0,  0};
  localparam int K_SAME [0:24]  = '{ 0,  0,  1,  0,  0,   0, -2,  0, -2,  0,
                                    -2,  8, 10,  8, -2,   0, -2,  0, -2,  0,
                                     0,  0,  1,  0,  0};
  localparam int K_DIFF [0:24]  = '{ 0,  0, -2,  0,  0,   0, -2,  8, -2,  0,
                                     1,  0, 10,  0,  1,   0, -2,  8, -2,  0,
                                     0,  0, -2,  0,  0};
  localparam int K_CROSS [0:24] = '{ 0, 0, -3, 0,  0,   0, 4,  0, 4,  0,
                                    -3, 0, 12, 0, -3,   0, 4,  0, 4,  0,
                                     0, 0, -3, 0,  0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] mosaic_sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] red_value_o, green_value_o, blue_value_o, pixel_row_o;
  logic [11:0] pixel_col_o;
  logic        last_of_run_o, frame_end_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  bayer_demosaic_5x5_linear_top uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]  line_mem [KEPT_ROWS*bdm_pkg::MAX_WIDTH];
  logic [1:0]   pattern_q = bdm_pkg::PAT_RGGB;
  logic [12:0]  width_q = 13'd1920;
  logic [15:0]  height_q = 16'd1080;
  int unsigned  in_row_q, in_col_q;
  rgb_pixel_t   pending_px[$];
  int           err_cnt, pixel_cnt, sample_cnt, frame_cnt;
  int unsigned  cyc;
  bit           no_idle;

  function automatic int eff_w();
    return (width_q < 4) ? 4 :
           (width_q > bdm_pkg::MAX_WIDTH) ? bdm_pkg::MAX_WIDTH : int'(width_q);
  endfunction

  function automatic int eff_h();
    return (height_q < 4) ? 4 : int'(height_q);
  endfunction

  function automatic int mirror(int k, int n);
    if (k < 0) return -k;
    if (k >= n) return 2*n - 2 - k;
    return k;
  endfunction

  function automatic longint fetch_px(int r, int c, int h, int w);
    return longint'(line_mem[(mirror(r, h) % KEPT_ROWS) * bdm_pkg::MAX_WIDTH
                             + (mirror(c, w) % bdm_pkg::MAX_WIDTH)]);
  endfunction

  // weighted 5x5 sum, divided by 16 with clamp and round half up
  function automatic logic [15:0] interp(kernel_e ker, int y, int x, int h, int w);
    longint acc;
    longint v;
    int     wt;
    acc = 0;
    for (int i = 0; i < 25; i++) begin
      case (ker)
        KER_GREEN:    wt = K_GREEN[i];
        KER_SAME_ROW: wt = K_SAME[i];
        KER_DIFF_ROW: wt = K_DIFF[i];
        default:      wt = K_CROSS[i];
      endcase
      if (wt != 0) acc += wt * fetch_px(y + i/5 - 2, x + i%5 - 2, h, w);
    end
    if (acc <= 0) return '0;
    v = (acc + 8) >>> 4;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic rgb_pixel_t demosaic_px(int y, int x, int h, int w);
    rgb_pixel_t p;
    bit         rr, rc, py, px;
    rr = (pattern_q == bdm_pkg::PAT_BGGR) || (pattern_q == bdm_pkg::PAT_GBRG);
    rc = (pattern_q == bdm_pkg::PAT_BGGR) || (pattern_q == bdm_pkg::PAT_GRBG);
    py = y[0];
    px = x[0];
    if (py == rr && px == rc) begin
      p.red   = 16'(fetch_px(y, x, h, w));
      p.green = interp(KER_GREEN, y, x, h, w);
      p.blue  = interp(KER_CROSS, y, x, h, w);
    end else if (py != rr && px != rc) begin
      p.blue  = 16'(fetch_px(y, x, h, w));
      p.green = interp(KER_GREEN, y, x, h, w);
      p.red   = interp(KER_CROSS, y, x, h, w);
    end else begin
      p.green = 16'(fetch_px(y, x, h, w));
      p.red   = interp(py == rr ? KER_SAME_ROW : KER_DIFF_ROW, y, x, h, w);
      p.blue  = interp(py == rr ? KER_DIFF_ROW : KER_SAME_ROW, y, x, h, w);
    end
    p.row  = y[15:0];
    p.col  = x[11:0];
    p.last = 1'b0;
    p.fend = (y == h-1) && (x == w-1);
    return p;
  endfunction

  // store one accepted sample and queue the pixels it releases
  function automatic void predict_sample(logic [15:0] s, logic flat);
    int w, h, yr, xc, y0, y1, x0, x1, n;
    rgb_pixel_t p;
    w = eff_w();
    h = eff_h();
    yr = int'(in_row_q);
    xc = int'(in_col_q);
    n = 0;
    line_mem[(yr % KEPT_ROWS) * bdm_pkg::MAX_WIDTH + (xc % bdm_pkg::MAX_WIDTH)] = s;
    if (yr == h-1) begin y0 = h-3; y1 = h-1; end
    else if (yr >= 2) begin y0 = yr-2; y1 = yr-2; end
    else begin y0 = 0; y1 = -1; end
    if (xc == w-1) begin x0 = w-3; x1 = w-1; end
    else if (xc >= 2) begin x0 = xc-2; x1 = xc-2; end
    else begin x0 = 0; x1 = -1; end
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++) begin
        p = demosaic_px(y, x, h, w);
        // a flat field reproduces its level in every color
        if (flat) begin
          p.red = s;
          p.green = s;
          p.blue = s;
        end
        p.last = (y == y1) && (x == x1);
        pending_px.push_back(p);
        n++;
      end
    if (xc + 1 >= w) begin
      in_col_q = 0;
      in_row_q = (yr + 1 >= h) ? 0 : yr + 1;
      if (yr + 1 >= h) frame_cnt++;
    end else begin
      in_col_q = xc + 1;
    end
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 16));
  endfunction

  // wait until every expected pixel is out and the pipeline has drained
  task automatic settle();
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      bdm_pkg::CFG_PATTERN: pattern_q = data[1:0];
      bdm_pkg::CFG_WIDTH:   width_q = data[12:0];
      bdm_pkg::CFG_HEIGHT:  height_q = data;
      default: ;
    endcase
    if (idx == bdm_pkg::CFG_WIDTH || idx == bdm_pkg::CFG_HEIGHT) begin
      in_row_q = 0;
      in_col_q = 0;
    end
  endtask

  // one sample beat; valid stays high across back-to-back beats
  task automatic send_sample(logic [15:0] s, logic flat);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mosaic_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(s, flat);
    sample_cnt++;
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      3:       return 16'hFF00 | 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // result side stall
  initial begin
    forever begin
      int stall;
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      rgb_pixel_t e;
      if (pending_px.size() == 0) begin
        $error("unexpected pixel row %0d col %0d", pixel_row_o, pixel_col_o);
        err_cnt++;
      end else begin
        e = pending_px.pop_front();
        pixel_cnt++;
        if (red_value_o !== e.red) begin
          $error("red_value exp %0d got %0d", e.red, red_value_o); err_cnt++;
        end
        if (green_value_o !== e.green) begin
          $error("green_value exp %0d got %0d", e.green, green_value_o); err_cnt++;
        end
        if (blue_value_o !== e.blue) begin
          $error("blue_value exp %0d got %0d", e.blue, blue_value_o); err_cnt++;
        end
        if (pixel_row_o !== e.row) begin
          $error("pixel_row exp %0d got %0d", e.row, pixel_row_o); err_cnt++;
        end
        if (pixel_col_o !== e.col) begin
          $error("pixel_col exp %0d got %0d", e.col, pixel_col_o); err_cnt++;
        end
        if (last_of_run_o !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, last_of_run_o); err_cnt++;
        end
        if (frame_end_o !== e.fend) begin
          $error("frame_end exp %0d got %0d", e.fend, frame_end_o); err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout with %0d pixels outstanding", pending_px.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  mosaic_row_t stim_tbl[$];

  initial begin
    int w, h, n;
    for (int i = 0; i < KEPT_ROWS*bdm_pkg::MAX_WIDTH; i++) line_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: width below range raised to 4, height below range raised to 4
    no_idle = 1'b1;
    write_reg(bdm_pkg::CFG_WIDTH, 16'd0);
    write_reg(bdm_pkg::CFG_HEIGHT, 16'd3);
    for (int i = 0; i < 16; i++) stim_tbl.push_back('{16'hFFFF, 1'b1});
    foreach (stim_tbl[i]) send_sample(stim_tbl[i].sample, stim_tbl[i].flat);
    end_burst();
    stim_tbl.delete();
    no_idle = 1'b0;
    write_reg(bdm_pkg::CFG_PATTERN, 16'(bdm_pkg::PAT_GRBG));
    stim_tbl = '{'{16'h0000, 1'b0}, '{16'hFFFF, 1'b0}, '{16'h0001, 1'b0},
                 '{16'h8000, 1'b0}, '{16'h7FFF, 1'b0}, '{16'h5555, 1'b0},
                 '{16'hAAAA, 1'b0}, '{16'hFFFF, 1'b0}, '{16'hFFFF, 1'b0},
                 '{16'h0000, 1'b0}, '{16'hFFFF, 1'b0}, '{16'h0000, 1'b0},
                 '{16'h0000, 1'b0}, '{16'hFFFF, 1'b0}, '{16'h0000, 1'b0},
                 '{16'hFFFF, 1'b0}};
    foreach (stim_tbl[i]) send_sample(stim_tbl[i].sample, stim_tbl[i].flat);
    end_burst();

    // extremes: widest rows (no pixels reach out), and the tallest frame
    write_reg(bdm_pkg::CFG_WIDTH, 16'hFFFF);
    write_reg(bdm_pkg::CFG_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), 1'b0);
    end_burst();
    write_reg(bdm_pkg::CFG_WIDTH, 16'd4);
    for (int i = 0; i < 24; i++) send_sample(rand_sample(), 1'b0);
    end_burst();

    // random frames, mostly whole, some cut short by a resize
    while (sample_cnt < ITEM_TARGET) begin
      w = ($urandom_range(0, 4) == 0) ? 5 + 2*int'($urandom_range(0, 1))
                                      : 2*int'($urandom_range(2, 5));
      h = 2*int'($urandom_range(2, 4));
      no_idle = ($urandom_range(0, 3) == 0);
      write_reg(bdm_pkg::CFG_PATTERN, 16'($urandom_range(0, 3)));
      write_reg(bdm_pkg::CFG_WIDTH, 16'(w));
      write_reg(bdm_pkg::CFG_HEIGHT, 16'(h));
      n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, w*h))
                                      : w*h*int'($urandom_range(1, 2));
      if (n > ITEM_TARGET - sample_cnt) n = ITEM_TARGET - sample_cnt;
      for (int i = 0; i < n; i++) send_sample(rand_sample(), 1'b0);
      end_burst();
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    end

    settle();
    $display("sent %0d samples, checked %0d pixels over %0d full frames",
             sample_cnt, pixel_cnt, frame_cnt);
    $display("all four patterns, clamped and odd sizes, flat and extreme fields");
    if (err_cnt == 0 && pending_px.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
